### rtl/bcov_pkg.sv
// Shared types, constants and helper functions for the binned coverage accumulator.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package bcov_pkg;

    // Sizing of the coverage store
    localparam int TARGETS         = 16;
    localparam int BINS_PER_TARGET = 4096;
    localparam int COUNT_WIDTH     = 32;

    // Fixed request and result field widths
    localparam int TGT_W      = 4;
    localparam int START_W    = 31;
    localparam int MQ_W       = 8;
    localparam int WORD_W     = 32;
    localparam int OPC_W      = 4;
    localparam int LEN_W      = WORD_W - OPC_W;
    localparam int BINF_W     = 12;
    localparam int SPAN_W     = 32;
    localparam int OUT_W      = 32;
    localparam int BS_W       = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Derived widths
    localparam int MEM_DEPTH = TARGETS * BINS_PER_TARGET;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int BIN_W     = $clog2(BINS_PER_TARGET);
    // reference positions below the end of the last bin of a target
    localparam int LIM_W     = BIN_W + BS_W;
    localparam int BND_W     = LIM_W + 1;
    localparam int WIDE_W    = (LIM_W > SPAN_W + 1) ? LIM_W : SPAN_W + 1;
    localparam int SUM_W     = ((COUNT_WIDTH > BS_W) ? COUNT_WIDTH : BS_W) + 1;
    localparam int DCNT_W    = $clog2(BIN_W + 1);

    // Register reset values
    localparam logic [MQ_W-1:0] MIN_QUALITY_RST = MQ_W'(30);
    localparam logic [BS_W-1:0] BIN_SIZE_RST    = BS_W'(50);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUALITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE    = 1'b1;

    // Request and result codes
    localparam logic OPN_ELEMENT  = 1'b0;
    localparam logic OPN_BIN_READ = 1'b1;
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_COUNT   = 1'b1;

    // CIGAR operations that consume reference
    localparam logic [OPC_W-1:0] CIGAR_MATCH = 4'h0;
    localparam logic [OPC_W-1:0] CIGAR_DEL   = 4'h2;

    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    localparam t_count CNT_MAX = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ELEM,
        S_DIV,
        S_RD,
        S_WR,
        S_BRD,
        S_DONE
    } t_state;

    // Write request into the coverage store
    typedef struct packed {
        logic   en;
        t_addr  addr;
        t_count data;
    } t_mem_wr;

    // Bin index and offset within that bin
    typedef struct packed {
        logic [BIN_W-1:0] quo;
        logic [LIM_W-1:0] rem;
    } t_div_res;

    function automatic logic tgt_ok(input logic [TGT_W-1:0] tgt);
        return 32'(tgt) < 32'(TARGETS);
    endfunction

    function automatic logic bin_ok(input logic [BINF_W-1:0] bin);
        return 32'(bin) < 32'(BINS_PER_TARGET);
    endfunction

    function automatic t_addr bin_addr(input logic [TGT_W-1:0] tgt,
                                       input logic [BIN_W-1:0] bin);
        return t_addr'(ADDR_W'(tgt) * ADDR_W'(BINS_PER_TARGET)) + ADDR_W'(bin);
    endfunction

    // Clamp a stored count to the 32-bit result field
    function automatic logic [OUT_W-1:0] sat_out(input t_count c);
        logic [63:0] w;
        w = 64'(c);
        return (w > 64'hFFFF_FFFF) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/bcov_store.sv
// Coverage store: one write port, one registered read port, no reset on the array.
// Depends on bcov_pkg.
`default_nettype none

module bcov_store
    import bcov_pkg::*;
(
    input  wire logic    i_clk,
    input  wire t_mem_wr i_wr,
    input  wire logic    i_rd_en,
    input  wire t_addr   i_rd_addr,
    output logic [COUNT_WIDTH-1:0] o_rd_data
);

    t_count r_mem [MEM_DEPTH];
    t_count r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read port, data registered and held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/bcov_bin_div.sv
// Restoring divider: reference position / bin size, one quotient bit per cycle.
// Depends on bcov_pkg. Quotient is the bin, remainder the offset inside it.
`default_nettype none

module bcov_bin_div
    import bcov_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [LIM_W-1:0] i_dividend,
    input  wire logic [BS_W-1:0]  i_divisor,
    output logic                  o_done,
    output t_div_res              o_res
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [LIM_W-1:0]  r_rem;
    logic [LIM_W-1:0]  r_den;
    logic [BIN_W-1:0]  r_quo;
    logic              ge;

    assign ge = (r_rem >= r_den);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(BIN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-subtract datapath; quotient is known to fit BIN_W bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_den <= LIM_W'(i_divisor) << (BIN_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_den;
            end
            r_quo <= {r_quo[BIN_W-2:0], ge};
            r_den <= r_den >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_res.quo = r_quo;
    assign o_res.rem = r_rem;

endmodule

`default_nettype wire

### rtl/binned_read_coverage_accumulator_core.sv
// Top level of the binned read coverage accumulator: sequencer, read state, output register.
// Depends on bcov_pkg, bcov_store and bcov_bin_div.
//
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_stall    operation, target, start_position,
//                                                  map_quality, cigar_word, first_element,
//                                                  bin_index
//  result    out        o_out_valid / i_out_stall  kind, bin_count, reference_span, dropped
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
//  After reset a clearing pass zeroes all 65536 store entries, one entry per cycle;
//  requests are stalled until it ends, config writes are taken throughout.
//  Bin read: one store read, then the result. Element without coverage: no store access.
//  Element with coverage: 12 divider steps to find the first bin, then one
//  store read and one store write per bin over the single read and write port.
//  A new request is taken while a result waits in the output register; i_out_stall
//  only holds the block once a second result is ready.
`default_nettype none

module binned_read_coverage_accumulator_core
    import bcov_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_operation,
    input  wire logic [TGT_W-1:0]      i_target,
    input  wire logic [START_W-1:0]    i_start_position,
    input  wire logic [MQ_W-1:0]       i_map_quality,
    input  wire logic [WORD_W-1:0]     i_cigar_word,
    input  wire logic                  i_first_element,
    input  wire logic [BINF_W-1:0]     i_bin_index,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_kind,
    output logic [OUT_W-1:0]           o_bin_count,
    output logic [SPAN_W-1:0]          o_reference_span,
    output logic                       o_dropped,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    // configuration registers
    logic [MQ_W-1:0] r_min_quality;
    logic [BS_W-1:0] r_bin_size;

    // read state
    logic [SPAN_W-1:0] r_cursor;
    logic [SPAN_W-1:0] r_span;
    logic [TGT_W-1:0]  r_tgt;
    logic              r_qual;

    // latched request
    logic              r_op;
    logic [WORD_W-1:0] r_word;
    logic [TGT_W-1:0]  r_rd_tgt;
    logic [BINF_W-1:0] r_rd_bin;
    logic              r_rd_oor;

    // bin walk
    logic [BIN_W-1:0]  r_bin;
    logic [LIM_W-1:0]  r_pos;
    logic [LIM_W-1:0]  r_hi;
    logic [BND_W-1:0]  r_bend;
    logic [BS_W-1:0]   r_add;
    logic              r_last;
    logic              r_drop;
    t_addr             r_clr_addr;

    // output register
    logic              r_out_valid;
    logic              r_kind;
    logic [OUT_W-1:0]  r_bin_count;
    logic [SPAN_W-1:0] r_out_span;
    logic              r_dropped;

    // combinational
    logic              accept;
    logic              out_load;
    logic              rd_en;
    t_addr             rd_addr;
    t_mem_wr           wr;
    logic              div_start;
    logic              div_done;
    t_div_res          div_res;
    t_count            rd_data;
    logic [BS_W-1:0]   bs_eff;
    logic [LIM_W-1:0]  limit;
    t_addr             walk_addr;

    // element decode
    logic [OPC_W-1:0]  el_op;
    logic [LEN_W-1:0]  el_len;
    logic              el_consume;
    logic [SPAN_W:0]   cur_sum;
    logic [SPAN_W:0]   span_sum;
    logic [WIDE_W-1:0] hi_w;
    logic [WIDE_W-1:0] lim_w;
    logic [WIDE_W-1:0] lo_w;
    logic              el_over;
    logic [WIDE_W-1:0] hi_c;
    logic              el_active;
    logic              el_tgt_bad;
    logic              el_drop;
    logic              el_walk;

    // bin step
    logic [BND_W-1:0]  seg_end;
    logic [SUM_W-1:0]  cell_sum;
    t_count            cell_new;

    bcov_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bcov_bin_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_cursor[LIM_W-1:0]),
        .i_divisor  (bs_eff),
        .o_done     (div_done),
        .o_res      (div_res)
    );

    // bin size of zero behaves as one
    assign bs_eff    = (r_bin_size == '0) ? BS_W'(1) : r_bin_size;
    assign limit     = LIM_W'(BINS_PER_TARGET) * LIM_W'(bs_eff);
    assign accept    = i_in_valid && !o_in_stall;
    assign walk_addr = bin_addr(r_tgt, r_bin);

    // element decode: clip the covered range to the target's bins
    always_comb begin
        el_op      = r_word[OPC_W-1:0];
        el_len     = r_word[WORD_W-1:OPC_W];
        el_consume = (el_op == CIGAR_MATCH) || (el_op == CIGAR_DEL);
        cur_sum    = {1'b0, r_cursor} + (SPAN_W + 1)'(el_len);
        span_sum   = {1'b0, r_span} + (SPAN_W + 1)'(el_len);
        hi_w       = WIDE_W'(cur_sum);
        lim_w      = WIDE_W'(limit);
        lo_w       = WIDE_W'(r_cursor);
        el_over    = hi_w > lim_w;
        hi_c       = el_over ? lim_w : hi_w;
        el_active  = el_consume && r_qual && (el_len != '0);
        el_tgt_bad = !tgt_ok(r_tgt);
        el_drop    = el_active && (el_tgt_bad || el_over);
        el_walk    = el_active && !el_tgt_bad && (lo_w < hi_c);
    end

    // bin step: overlap with the current bin, then saturating add
    always_comb begin
        seg_end  = (r_bend < BND_W'(r_hi)) ? r_bend : BND_W'(r_hi);
        cell_sum = SUM_W'(rd_data) + SUM_W'(r_add);
        cell_new = (cell_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : cell_sum[COUNT_WIDTH-1:0];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and store controls; one store access at a time, so a read
    // never overlaps the write of the same entry
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        rd_addr    = walk_addr;
        wr.en      = 1'b0;
        wr.addr    = walk_addr;
        wr.data    = cell_new;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                wr.en   = 1'b1;
                wr.addr = r_clr_addr;
                wr.data = '0;
                if (r_clr_addr == t_addr'(MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = (i_operation == OPN_BIN_READ) ? S_BRD : S_ELEM;
                end
            end
            S_ELEM: begin
                div_start = el_walk;
                n_state   = el_walk ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                wr.en   = 1'b1;
                n_state = r_last ? S_DONE : S_RD;
            end
            S_BRD: begin
                rd_en   = 1'b1;
                rd_addr = bin_addr(r_rd_tgt, BIN_W'(r_rd_bin));
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_quality <= MIN_QUALITY_RST;
            r_bin_size    <= BIN_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_QUALITY: r_min_quality <= i_cfg_data[MQ_W-1:0];
                CFG_BIN_SIZE:    r_bin_size    <= i_cfg_data[BS_W-1:0];
                default:         ;
            endcase
        end
    end

    // read state: latched on a first element, advanced by consuming ops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_span   <= '0;
            r_tgt    <= '0;
            r_qual   <= 1'b0;
        end else if (accept && (i_operation == OPN_ELEMENT) && i_first_element) begin
            r_cursor <= {1'b0, i_start_position};
            r_span   <= '0;
            r_tgt    <= i_target;
            r_qual   <= (i_map_quality >= r_min_quality);
        end else if ((r_state == S_ELEM) && el_consume) begin
            r_cursor <= cur_sum[SPAN_W] ? {SPAN_W{1'b1}} : cur_sum[SPAN_W-1:0];
            r_span   <= span_sum[SPAN_W] ? {SPAN_W{1'b1}} : span_sum[SPAN_W-1:0];
        end
    end

    // clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr_addr <= r_clr_addr + t_addr'(1);
        end
    end

    // request latch and bin walk datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_operation;
            r_word   <= i_cigar_word;
            r_rd_tgt <= i_target;
            r_rd_bin <= i_bin_index;
        end
        unique case (r_state)
            S_ELEM: begin
                r_drop <= el_drop;
                r_pos  <= r_cursor[LIM_W-1:0];
                r_hi   <= hi_c[LIM_W-1:0];
            end
            S_DIV: begin
                r_bin  <= div_res.quo;
                r_bend <= BND_W'(r_pos) - BND_W'(div_res.rem) + BND_W'(bs_eff);
            end
            S_RD: begin
                r_add  <= BS_W'(seg_end - BND_W'(r_pos));
                r_last <= (seg_end == BND_W'(r_hi));
                r_pos  <= seg_end[LIM_W-1:0];
            end
            S_WR: begin
                r_bin  <= r_bin + BIN_W'(1);
                r_bend <= r_bend + BND_W'(bs_eff);
            end
            S_BRD: begin
                r_rd_oor <= !tgt_ok(r_rd_tgt) || !bin_ok(r_rd_bin);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_op == OPN_BIN_READ) begin
                r_kind      <= KIND_COUNT;
                r_bin_count <= r_rd_oor ? '0 : sat_out(rd_data);
                r_out_span  <= '0;
                r_dropped   <= 1'b0;
            end else begin
                r_kind      <= KIND_ACK;
                r_bin_count <= '0;
                r_out_span  <= r_span;
                r_dropped   <= r_drop;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_bin_count      = r_bin_count;
    assign o_reference_span = r_out_span;
    assign o_dropped        = r_dropped;

    // a result appears only out of the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

    // the bin walk never starts a bin at or past the clipped end
    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_pos < r_hi))
        else $error("bin walk past covered range");

    // no store read while the clearing sweep runs
    a_no_read_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !rd_en)
        else $error("store read during clearing pass");

    // an accepted request always leaves idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted request not started");

endmodule

`default_nettype wire
